/* hw/rtl/cts_pkg.sv */
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, constants and the CORDIC angle table for the converter.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;
    localparam int GUARD             = 12;  // fraction bits added ahead of the chains
    localparam int QUEUE_DEPTH       = 4;

    // atan(2^-i) in Q32 turns
    localparam logic [31:0] ATAN_Q32 [0:MAX_STAGES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] THREE_QTR  = 32'h C000_0000;

    // per-item class flags
    typedef struct packed {
        logic spatial;
        logic zero;    // zero vector
        logic axis;    // x = y = 0
        logic z_pos;
    } t_flags;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // squared CORDIC gain in Q30 (product of 1 + 2^-2i over the stages)
    function automatic logic [63:0] cts_gain_p(input int stages);
        logic [63:0] p;
        p = 64'd1 << 30;
        for (int i = 0; i < stages; i++) begin
            p = p + (p >> (2 * i));
        end
        return p;
    endfunction

endpackage

/* hw/rtl/cts_front.sv */
// ----------------------------------------------------------------------------
// cts_front
// Input register: takes a point, classifies it and hands it to the queue.
// ----------------------------------------------------------------------------
module cts_front import cts_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_z,
    input  logic                          i_full,
    output logic                          o_push,
    output t_flags                        o_flags,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y,
    output logic signed [COORD_WIDTH-1:0] o_z
);

    logic                          r_valid;
    t_flags                        r_flags;
    logic signed [COORD_WIDTH-1:0] r_x, r_y, r_z;
    logic                          accept;
    logic signed [COORD_WIDTH-1:0] z_eff;
    logic                          xy_zero;

    assign o_ready = !r_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign z_eff   = i_mode ? i_z : '0;  // planar points sit at z = 0
    assign xy_zero = (i_x == '0) && (i_y == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_full) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_flags.spatial <= i_mode;
            r_flags.zero    <= xy_zero && (z_eff == '0);
            r_flags.axis    <= xy_zero;
            r_flags.z_pos   <= (z_eff > 0);
            r_x             <= i_x;
            r_y             <= i_y;
            r_z             <= z_eff;
        end
    end

    assign o_push  = r_valid;
    assign o_flags = r_flags;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

/* hw/rtl/cts_queue.sv */
// ----------------------------------------------------------------------------
// cts_queue
// Short FIFO between front and back, register based.
// ----------------------------------------------------------------------------
module cts_queue import cts_pkg::*; #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic                  i_pop,
    output logic [DATA_WIDTH-1:0] o_data,
    output t_q_stat               o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]         r_wr, r_rd;
    logic [AW:0]           r_cnt;
    logic                  wr, rd;

    assign o_stat.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign wr = i_push && !o_stat.full;
    assign rd = i_pop && !o_stat.empty;
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hw/rtl/cts_back.sv */
// ----------------------------------------------------------------------------
// cts_back
// Two pipelined CORDIC vectoring chains, radius scaling and output register.
// ----------------------------------------------------------------------------
module cts_back import cts_pkg::*; #(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_q_stat                       i_q_stat,
    output logic                          o_pop,
    input  t_flags                        i_flags,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_valid_point,
    output logic [COORD_WIDTH-1:0]        o_radius,
    output logic [ANGLE_WIDTH-1:0]        o_polar,
    output logic [ANGLE_WIDTH-1:0]        o_azimuth
);

    localparam int W  = COORD_WIDTH + GUARD + 4;
    localparam int CS = CORDIC_STAGES;
    localparam int SH = 32 - ANGLE_WIDTH;
    localparam int RS = 30 + GUARD - 16;
    localparam logic [63:0] GAIN_P = cts_gain_p(CORDIC_STAGES);
    localparam logic [63:0] INVK2  = ((64'd1 << 60) + GAIN_P / 2) / GAIN_P;
    localparam logic [31:0] INVK2_32 = INVK2[31:0];

    logic en;

    // chain 1: (x, y) -> planar length, azimuth
    logic                r_v1 [0:CS];
    t_flags              r_f1 [0:CS];
    logic signed [W-1:0] r_x1 [0:CS];
    logic signed [W-1:0] r_y1 [0:CS];
    logic [31:0]         r_a1 [0:CS];
    logic signed [W-1:0] r_z1 [0:CS];
    // chain 2: (z, planar length) -> radius, polar angle
    logic                r_v2 [0:CS];
    t_flags              r_f2 [0:CS];
    logic signed [W-1:0] r_x2 [0:CS];
    logic signed [W-1:0] r_y2 [0:CS];
    logic [31:0]         r_a2 [0:CS];
    logic [31:0]         r_az [0:CS];

    logic signed [W-1:0] x_in, y_in, z_in;

    assign en    = !o_valid || i_ready;
    assign o_pop = en && !i_q_stat.empty;
    assign x_in  = W'(i_x) <<< GUARD;
    assign y_in  = W'(i_y) <<< GUARD;
    assign z_in  = W'(i_z) <<< GUARD;

    // chain 1 entry: fold left half plane over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1[0] <= 1'b0;
        end else if (en) begin
            r_v1[0] <= !i_q_stat.empty;
        end
        if (en) begin
            r_f1[0] <= i_flags;
            r_z1[0] <= z_in;
            if (x_in[W-1]) begin
                r_x1[0] <= -x_in;
                r_y1[0] <= -y_in;
                r_a1[0] <= HALF_TURN;
            end else begin
                r_x1[0] <= x_in;
                r_y1[0] <= y_in;
                r_a1[0] <= '0;
            end
        end
    end

    for (genvar s = 0; s < CS; s++) begin : g_c1
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v1[s+1] <= 1'b0;
            end else if (en) begin
                r_v1[s+1] <= r_v1[s];
            end
            if (en) begin
                r_f1[s+1] <= r_f1[s];
                r_z1[s+1] <= r_z1[s];
                if (!r_y1[s][W-1]) begin
                    r_x1[s+1] <= r_x1[s] + (r_y1[s] >>> s);
                    r_y1[s+1] <= r_y1[s] - (r_x1[s] >>> s);
                    r_a1[s+1] <= r_a1[s] + ATAN_Q32[s];
                end else begin
                    r_x1[s+1] <= r_x1[s] - (r_y1[s] >>> s);
                    r_y1[s+1] <= r_y1[s] + (r_x1[s] >>> s);
                    r_a1[s+1] <= r_a1[s] - ATAN_Q32[s];
                end
            end
        end
    end

    // chain 2 entry: vector is (z, planar length)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2[0] <= 1'b0;
        end else if (en) begin
            r_v2[0] <= r_v1[CS];
        end
        if (en) begin
            r_f2[0] <= r_f1[CS];
            r_az[0] <= r_a1[CS];
            if (r_z1[CS][W-1]) begin
                r_x2[0] <= -r_z1[CS];
                r_y2[0] <= -r_x1[CS];
                r_a2[0] <= HALF_TURN;
            end else begin
                r_x2[0] <= r_z1[CS];
                r_y2[0] <= r_x1[CS];
                r_a2[0] <= '0;
            end
        end
    end

    for (genvar s = 0; s < CS; s++) begin : g_c2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v2[s+1] <= 1'b0;
            end else if (en) begin
                r_v2[s+1] <= r_v2[s];
            end
            if (en) begin
                r_f2[s+1] <= r_f2[s];
                r_az[s+1] <= r_az[s];
                if (!r_y2[s][W-1]) begin
                    r_x2[s+1] <= r_x2[s] + (r_y2[s] >>> s);
                    r_y2[s+1] <= r_y2[s] - (r_x2[s] >>> s);
                    r_a2[s+1] <= r_a2[s] + ATAN_Q32[s];
                end else begin
                    r_x2[s+1] <= r_x2[s] - (r_y2[s] >>> s);
                    r_y2[s+1] <= r_y2[s] + (r_x2[s] >>> s);
                    r_a2[s+1] <= r_a2[s] - ATAN_Q32[s];
                end
            end
        end
    end

    // gain correction products, polar clamp
    logic        r_vm;
    t_flags      r_fm;
    logic [63:0] r_p_hi, r_p_lo;
    logic [31:0] r_pol, r_azm;
    logic [W-1:0] mag;
    logic [31:0]  pol_c;

    assign mag = r_x2[CS][W-1] ? '0 : r_x2[CS];

    always_comb begin
        if (r_f2[CS].axis) begin
            pol_c = r_f2[CS].z_pos ? '0 : HALF_TURN;
        end else if (r_a2[CS] > THREE_QTR) begin
            pol_c = '0;
        end else if (r_a2[CS] > HALF_TURN) begin
            pol_c = HALF_TURN;
        end else begin
            pol_c = r_a2[CS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (en) begin
            r_vm <= r_v2[CS];
        end
        if (en) begin
            r_fm   <= r_f2[CS];
            r_p_hi <= 64'(mag[W-1:16]) * 64'(INVK2_32);
            r_p_lo <= (64'(mag[15:0]) * 64'(INVK2_32)) >> 16;
            r_pol  <= pol_c;
            r_azm  <= r_f2[CS].axis ? '0 : r_az[CS];
        end
    end

    // rounding, saturation, output register
    logic [63:0] rad_full;
    logic [31:0] pol_r, az_r;

    assign rad_full = (r_p_hi + r_p_lo + (64'd1 << (RS - 1))) >> RS;
    assign pol_r    = r_pol + (32'd1 << (SH - 1));
    assign az_r     = r_azm + (32'd1 << (SH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_vm;
        end
        if (en) begin
            o_valid_point <= !r_fm.zero;
            if (r_fm.zero) begin
                o_radius  <= '0;
                o_polar   <= '0;
                o_azimuth <= '0;
            end else begin
                o_radius  <= (rad_full > 64'({COORD_WIDTH{1'b1}})) ? '1
                           : rad_full[COORD_WIDTH-1:0];
                o_polar   <= r_fm.spatial ? pol_r[31:SH]
                           : ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
                o_azimuth <= az_r[31:SH];
            end
        end
    end

endmodule

/* hw/rtl/cartesian_to_spherical.sv */
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Stream converter from (x, y, z) to radius, polar angle and azimuth.
// ----------------------------------------------------------------------------
// One point enters per cycle and one result word leaves per cycle while
// the output is not stalled. Each point passes the front register, queue,
// both chains, gain register and output register, and may wait in the queue.
// The rate is set by the two fully pipelined CORDIC vectoring chains: the
// first turns (x, y) onto +x, giving azimuth and planar length, the second
// turns (z, planar length), giving polar angle and the raw radius. The raw
// radius is scaled by 1/K^2 through two narrow multipliers. A front register
// classifies each point (zero vector, point on the z axis, planar or
// spatial) and feeds a four-word queue, so input and output stall apart.
// Angles are in units of one turn / 2^ANGLE_WIDTH; azimuth covers a full
// turn, polar angle 0 .. half turn (quarter turn in planar mode). A zero
// vector gives valid_point = 0 and zero fields.
// ----------------------------------------------------------------------------
module cartesian_to_spherical import cts_pkg::*; #(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    localparam int IN_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((COORD_WIDTH + 2 * ANGLE_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z
    input  logic             s_tuser,   // mode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // radius, polar_angle, azimuth
    output logic             m_tuser    // valid_point
);

    localparam int QW = 3 * COORD_WIDTH + $bits(t_flags);

    logic                          push;
    t_flags                        f_flags, q_flags;
    logic signed [COORD_WIDTH-1:0] f_x, f_y, f_z, q_x, q_y, q_z;
    logic [QW-1:0]                 q_dout;
    t_q_stat                       q_stat;
    logic                          pop;
    logic [COORD_WIDTH-1:0]        radius;
    logic [ANGLE_WIDTH-1:0]        polar, azimuth;

    cts_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_mode  (s_tuser),
        .i_x     (s_tdata[COORD_WIDTH-1:0]),
        .i_y     (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_z     (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .i_full  (q_stat.full),
        .o_push  (push),
        .o_flags (f_flags),
        .o_x     (f_x),
        .o_y     (f_y),
        .o_z     (f_z)
    );

    cts_queue #(.DATA_WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_flags, f_z, f_y, f_x}),
        .i_pop   (pop),
        .o_data  (q_dout),
        .o_stat  (q_stat)
    );

    assign q_x     = q_dout[COORD_WIDTH-1:0];
    assign q_y     = q_dout[2*COORD_WIDTH-1:COORD_WIDTH];
    assign q_z     = q_dout[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign q_flags = q_dout[QW-1:3*COORD_WIDTH];

    cts_back #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .i_flags       (q_flags),
        .i_x           (q_x),
        .i_y           (q_y),
        .i_z           (q_z),
        .o_valid       (m_tvalid),
        .i_ready       (m_tready),
        .o_valid_point (m_tuser),
        .o_radius      (radius),
        .o_polar       (polar),
        .o_azimuth     (azimuth)
    );

    assign m_tdata = OUT_W'({azimuth, polar, radius});

    // zero vector gives all-zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("zero vector with nonzero fields");

    // polar angle never passes a half turn
    a_polar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> polar <= (ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1)))
        else $error("polar angle out of range");

    // queue only popped when it holds a word
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule
